@@ rtl/core/tdat_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdat_pkg
// Shared types and constants for the time-of-day clock with alarm table.
// ----------------------------------------------------------------------------
package tdat_pkg;

  localparam int unsigned ALARM_SLOTS_DEF = 16;

  localparam logic [5:0] SEC_LAST = 6'd59;
  localparam logic [5:0] MIN_LAST = 6'd59;
  localparam logic [4:0] HR_LAST  = 5'd23;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_ADD  = 1'b1
  } tdat_req_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } tdat_time_t;

  typedef struct packed {
    logic       enable;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } tdat_slot_t;

endpackage

@@ rtl/core/tdat_clock.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdat_clock
// Hours, minutes and seconds counter that advances by one second per tick.
// ----------------------------------------------------------------------------
module tdat_clock
  import tdat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tick_en,
  output tdat_time_t now
);

  tdat_time_t now_r;
  tdat_time_t now_nxt;

  always_comb begin
    now_nxt = now_r;
    if (tick_en) begin
      if (now_r.seconds >= SEC_LAST) begin
        now_nxt.seconds = '0;
        if (now_r.minutes >= MIN_LAST) begin
          now_nxt.minutes = '0;
          if (now_r.hours >= HR_LAST) begin
            now_nxt.hours = '0;
          end else begin
            now_nxt.hours = now_r.hours + 5'd1;
          end
        end else begin
          now_nxt.minutes = now_r.minutes + 6'd1;
        end
      end else begin
        now_nxt.seconds = now_r.seconds + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
    end else begin
      now_r <= now_nxt;
    end
  end

  assign now = now_r;

`ifndef SYNTHESIS
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    now_r.seconds <= SEC_LAST && now_r.minutes <= MIN_LAST && now_r.hours <= HR_LAST)
    else $error("time of day out of range");

  a_sec_step: assert property (@(posedge clk) disable iff (!rst_n)
    tick_en && now_r.seconds != SEC_LAST |=>
      now_r.seconds == $past(now_r.seconds) + 6'd1 && $stable(now_r.minutes))
    else $error("seconds did not advance on tick");

  a_day_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    tick_en && now_r.seconds == SEC_LAST && now_r.minutes == MIN_LAST &&
      now_r.hours == HR_LAST |=> now_r == '0)
    else $error("midnight rollover failed");
`endif

endmodule

@@ rtl/core/tdat_slots.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdat_slots
// Alarm slot table filled in order, with a parallel compare against the time.
// ----------------------------------------------------------------------------
module tdat_slots
  import tdat_pkg::*;
#(
  parameter int unsigned ALARM_SLOTS = ALARM_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       add_en,
  input  tdat_slot_t add_slot,
  input  tdat_time_t now,
  output logic       add_ok,
  output logic       hit
);

  localparam int unsigned CNT_W = $clog2(ALARM_SLOTS + 1);
  localparam int unsigned IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

  logic [CNT_W-1:0]       filled_r;
  tdat_slot_t             slot_r [ALARM_SLOTS];
  logic [ALARM_SLOTS-1:0] match;
  logic                   full;

  assign full   = (filled_r == CNT_W'(ALARM_SLOTS));
  assign add_ok = add_en && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
    end else if (add_ok) begin
      filled_r <= filled_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (add_ok) begin
      slot_r[filled_r[IDX_W-1:0]] <= add_slot;
    end
  end

  // Only slots below the fill count hold data; the rest are never trusted.
  always_comb begin
    for (int k = 0; k < ALARM_SLOTS; k++) begin
      match[k] = (CNT_W'(k) < filled_r) && slot_r[k].enable &&
                 slot_r[k].hours == now.hours &&
                 slot_r[k].minutes == now.minutes &&
                 slot_r[k].seconds == now.seconds;
    end
  end

  assign hit = |match;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CNT_W'(ALARM_SLOTS))
    else $error("fill count beyond table size");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    add_ok |=> filled_r == $past(filled_r) + 1'b1)
    else $error("fill count did not advance on store");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    full |=> $stable(filled_r))
    else $error("fill count moved while table full");
`endif

endmodule

@@ rtl/core/time_of_day_alarm_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_alarm_table
// 24-hour time-of-day clock with an in-order alarm slot table.
// ----------------------------------------------------------------------------
// A word is taken at a rising edge where start is high and busy is low; busy
// stays low, so a word can be issued in every cycle. in_req_type selects a
// one-second tick or the store of an alarm (in_alarm_* fields) into the next
// free slot. Each word yields one result word: out_strobe is high for exactly
// one cycle, after the accepting edge and the registered capture, with out_accepted,
// out_alarm_hit and the time after the step on out_now_*.
// Throughput is one word per cycle; each result passes the state update at the
// accepting edge and then the registered slot compare after it.
// The receiver cannot hold results off, and none is needed: results leave in
// order, one per accepted word.
// Reset clears the time to 00:00:00, empties the table and drops any result
// in flight. Slot contents are not cleared; the fill count alone marks which
// slots are live. Slots are never removed, and a store into a full table is
// refused with out_accepted low.
// ----------------------------------------------------------------------------
module time_of_day_alarm_table
  import tdat_pkg::*;
#(
  parameter int unsigned ALARM_SLOTS = ALARM_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_req_type,
  input  logic [5:0] in_alarm_seconds,
  input  logic [5:0] in_alarm_minutes,
  input  logic [4:0] in_alarm_hours,
  input  logic       in_alarm_enable,
  output logic       out_strobe,
  output logic       out_accepted,
  output logic       out_alarm_hit,
  output logic [5:0] out_now_seconds,
  output logic [5:0] out_now_minutes,
  output logic [4:0] out_now_hours
);

  logic       accept;
  logic       tick_en;
  logic       add_en;
  logic       add_ok;
  logic       hit;
  tdat_req_t  req;
  tdat_time_t now;
  tdat_slot_t add_slot;

  logic       step_r;
  logic       acc_r;
  logic       strobe_r;
  logic       accepted_r;
  logic       hit_r;
  tdat_time_t time_r;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign req     = tdat_req_t'(in_req_type);
  assign tick_en = accept && (req == REQ_TICK);
  assign add_en  = accept && (req == REQ_ADD);

  assign add_slot = '{enable:  in_alarm_enable,
                      hours:   in_alarm_hours,
                      minutes: in_alarm_minutes,
                      seconds: in_alarm_seconds};

  tdat_clock u_clock (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (tick_en),
    .now     (now)
  );

  tdat_slots #(
    .ALARM_SLOTS (ALARM_SLOTS)
  ) u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .add_en   (add_en),
    .add_slot (add_slot),
    .now      (now),
    .add_ok   (add_ok),
    .hit      (hit)
  );

  // The state registers settle at the accepting edge; the cycle after, they
  // hold exactly the post-step state, which is compared and captured.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      step_r   <= accept;
      strobe_r <= step_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= add_ok;
    accepted_r <= acc_r;
    hit_r      <= hit;
    time_r     <= now;
  end

  assign out_strobe      = strobe_r;
  assign out_accepted    = strobe_r && accepted_r;
  assign out_alarm_hit   = hit_r;
  assign out_now_seconds = time_r.seconds;
  assign out_now_minutes = time_r.minutes;
  assign out_now_hours   = time_r.hours;

`ifndef SYNTHESIS
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 2))
    else $error("result word without a matching input word");

  a_word_lat: assert property (@(posedge clk) disable iff (!rst_n)
    step_r |=> out_strobe)
    else $error("accepted word produced no result");

  a_acc_add: assert property (@(posedge clk) disable iff (!rst_n)
    out_accepted |-> $past(add_en, 2))
    else $error("store flagged for a tick word");
`endif

endmodule

@@ tb/alarm_clock_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_clock_checker
// Watches the word and result ports of the time-of-day alarm table, keeps its
// own copy of the clock and the slot table, and compares every result word
// with the next expected one. Failures are counted and handed to the top.
// ----------------------------------------------------------------------------
module alarm_clock_checker
  import tdat_pkg::*;
#(
  parameter int unsigned ALARM_SLOTS = ALARM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_req_type,
  input  logic [5:0]  in_alarm_seconds,
  input  logic [5:0]  in_alarm_minutes,
  input  logic [4:0]  in_alarm_hours,
  input  logic        in_alarm_enable,
  input  logic        out_strobe,
  input  logic        out_accepted,
  input  logic        out_alarm_hit,
  input  logic [5:0]  out_now_seconds,
  input  logic [5:0]  out_now_minutes,
  input  logic [4:0]  out_now_hours,
  output int unsigned fail_count,
  output int unsigned words_pending
);

  typedef struct packed {
    logic       accepted;
    logic       alarm_hit;
    tdat_time_t now;
  } clock_report_t;

  tdat_time_t    now_time;
  tdat_slot_t    slot_table [ALARM_SLOTS];
  int unsigned   slots_used;
  clock_report_t report_q [$];
  clock_report_t seen_word;
  clock_report_t due_word;

  initial begin
    fail_count    = 0;
    words_pending = 0;
  end

  function automatic void advance_second();
    if (now_time.seconds >= SEC_LAST) begin
      now_time.seconds = '0;
      if (now_time.minutes >= MIN_LAST) begin
        now_time.minutes = '0;
        if (now_time.hours >= HR_LAST) begin
          now_time.hours = '0;
        end else begin
          now_time.hours = now_time.hours + 5'd1;
        end
      end else begin
        now_time.minutes = now_time.minutes + 6'd1;
      end
    end else begin
      now_time.seconds = now_time.seconds + 6'd1;
    end
  endfunction

  function automatic logic armed_slot_matches();
    logic hit;
    hit = 1'b0;
    for (int unsigned k = 0; k < slots_used; k++) begin
      if (slot_table[k].enable && slot_table[k].hours == now_time.hours &&
          slot_table[k].minutes == now_time.minutes &&
          slot_table[k].seconds == now_time.seconds) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // An add leaves the time alone, and the new slot already takes part in the
  // compare of the same word.
  function automatic clock_report_t apply_word(tdat_req_t kind, tdat_slot_t alarm);
    clock_report_t rep;
    rep.accepted = 1'b0;
    if (kind == REQ_TICK) begin
      advance_second();
    end else if (slots_used < ALARM_SLOTS) begin
      slot_table[slots_used] = alarm;
      slots_used++;
      rep.accepted = 1'b1;
    end
    rep.alarm_hit = armed_slot_matches();
    rep.now       = now_time;
    return rep;
  endfunction

  task automatic note_failure(input string what, input logic has_due,
                              input clock_report_t want, input clock_report_t got);
    fail_count++;
    if (fail_count <= 10) begin
      if (has_due) begin
        $display("%0t ns %s: expected acc=%0b hit=%0b %0d:%0d:%0d, got acc=%0b hit=%0b %0d:%0d:%0d",
                 $time, what, want.accepted, want.alarm_hit, want.now.hours,
                 want.now.minutes, want.now.seconds, got.accepted, got.alarm_hit,
                 got.now.hours, got.now.minutes, got.now.seconds);
      end else begin
        $display("%0t ns %s: got acc=%0b hit=%0b %0d:%0d:%0d", $time, what,
                 got.accepted, got.alarm_hit, got.now.hours, got.now.minutes,
                 got.now.seconds);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      now_time   = '0;
      slots_used = 0;
      report_q.delete();
    end else begin
      if (out_strobe) begin
        seen_word = {out_accepted, out_alarm_hit, out_now_hours, out_now_minutes,
                     out_now_seconds};
        if (report_q.size() == 0) begin
          note_failure("unexpected result word", 1'b0, seen_word, seen_word);
        end else begin
          due_word = report_q.pop_front();
          if (seen_word !== due_word) begin
            note_failure("result word mismatch", 1'b1, due_word, seen_word);
          end
        end
      end
      if (start && !busy) begin
        report_q.push_back(apply_word(tdat_req_t'(in_req_type),
                                      {in_alarm_enable, in_alarm_hours,
                                       in_alarm_minutes, in_alarm_seconds}));
      end
    end
    words_pending = report_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the time-of-day alarm table. A directed opening
// covers field extremes and the add/tick corner cases, a random mix of ticks
// and alarm adds follows, and a closing run of ticks carries the clock across
// several minute rollovers while the armed slots keep being compared.
// ----------------------------------------------------------------------------
module tb_top;
  import tdat_pkg::*;

  localparam int unsigned SLOTS        = ALARM_SLOTS_DEF;
  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned RANDOM_WORDS = 1300;
  localparam int unsigned TAIL_TICKS   = 200;
  localparam int unsigned CYCLE_LIMIT  = 100000;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_req_type;
  logic [5:0] in_alarm_seconds;
  logic [5:0] in_alarm_minutes;
  logic [4:0] in_alarm_hours;
  logic       in_alarm_enable;
  logic       out_strobe;
  logic       out_accepted;
  logic       out_alarm_hit;
  logic [5:0] out_now_seconds;
  logic [5:0] out_now_minutes;
  logic [4:0] out_now_hours;

  int unsigned fail_count;
  int unsigned words_pending;
  int unsigned cycle_count;
  int unsigned tick_count;
  int unsigned burst_left;
  int unsigned max_gap;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  time_of_day_alarm_table #(
    .ALARM_SLOTS(SLOTS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_alarm_seconds (in_alarm_seconds),
    .in_alarm_minutes (in_alarm_minutes),
    .in_alarm_hours   (in_alarm_hours),
    .in_alarm_enable  (in_alarm_enable),
    .out_strobe       (out_strobe),
    .out_accepted     (out_accepted),
    .out_alarm_hit    (out_alarm_hit),
    .out_now_seconds  (out_now_seconds),
    .out_now_minutes  (out_now_minutes),
    .out_now_hours    (out_now_hours)
  );

  alarm_clock_checker #(
    .ALARM_SLOTS(SLOTS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_alarm_seconds (in_alarm_seconds),
    .in_alarm_minutes (in_alarm_minutes),
    .in_alarm_hours   (in_alarm_hours),
    .in_alarm_enable  (in_alarm_enable),
    .out_strobe       (out_strobe),
    .out_accepted     (out_accepted),
    .out_alarm_hit    (out_alarm_hit),
    .out_now_seconds  (out_now_seconds),
    .out_now_minutes  (out_now_minutes),
    .out_now_hours    (out_now_hours),
    .fail_count       (fail_count),
    .words_pending    (words_pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Time of day reached after a given number of ticks, used to aim alarms.
  function automatic tdat_time_t clock_from_ticks(int unsigned ticks);
    tdat_time_t t;
    int unsigned secs;
    secs      = ticks % SECS_PER_DAY;
    t.hours   = 5'(secs / 3600);
    t.minutes = 6'((secs / 60) % 60);
    t.seconds = 6'(secs % 60);
    return t;
  endfunction

  // Between bursts the sender idles for a random gap; a zero gap joins two
  // bursts into a longer stretch without idling.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, max_gap);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic send_word(input tdat_req_t kind, input logic [5:0] secs,
                           input logic [5:0] mins, input logic [4:0] hrs,
                           input logic armed);
    pace_sender();
    @(negedge clk);
    start            <= 1'b1;
    in_req_type      <= kind;
    in_alarm_seconds <= secs;
    in_alarm_minutes <= mins;
    in_alarm_hours   <= hrs;
    in_alarm_enable  <= armed;
    do begin
      @(posedge clk);
    end while (busy);
    if (kind == REQ_TICK) begin
      tick_count++;
    end
  endtask

  task automatic send_tick();
    send_word(REQ_TICK, 6'($urandom), 6'($urandom), 5'($urandom), 1'($urandom));
  endtask

  task automatic send_alarm(input tdat_time_t at, input logic armed);
    send_word(REQ_ADD, at.seconds, at.minutes, at.hours, armed);
  endtask

  initial begin
    int unsigned pick;
    cycle_count      = 0;
    tick_count       = 0;
    burst_left       = 0;
    max_gap          = 6;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_req_type      = REQ_TICK;
    in_alarm_seconds = '0;
    in_alarm_minutes = '0;
    in_alarm_hours   = '0;
    in_alarm_enable  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: alarms at the present time, a disarmed one, field
    // extremes, the midnight and last-second alarms, then ticks across them.
    send_tick();
    send_tick();
    send_alarm(clock_from_ticks(tick_count), 1'b0);
    send_alarm(clock_from_ticks(tick_count), 1'b1);
    send_alarm(clock_from_ticks(tick_count + 3), 1'b0);
    send_word(REQ_ADD, 6'h3f, 6'h3f, 5'h1f, 1'b1);
    send_word(REQ_ADD, 6'd0, 6'd0, 5'd0, 1'b1);
    send_word(REQ_ADD, SEC_LAST, MIN_LAST, HR_LAST, 1'b1);
    send_alarm(clock_from_ticks(tick_count + 6), 1'b1);
    send_word(REQ_TICK, 6'h3f, 6'h3f, 5'h1f, 1'b1);
    send_word(REQ_TICK, 6'd0, 6'd0, 5'd0, 1'b0);
    repeat (6) send_tick();

    // Random mix: mostly ticks, with adds aimed at the near future so that
    // they hit while the clock runs; once the table fills, adds are refused.
    repeat (RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        send_tick();
      end else if (pick < 90) begin
        send_alarm(clock_from_ticks(tick_count + $urandom_range(1, 40)),
                   ($urandom_range(0, 3) != 0));
      end else if (pick < 95) begin
        send_alarm(clock_from_ticks(tick_count), 1'($urandom));
      end else begin
        send_word(REQ_ADD, 6'($urandom), 6'($urandom), 5'($urandom), 1'($urandom));
      end
    end

    // A closing run of ticks crosses more minute rollovers and keeps the
    // armed slots in the compare.
    max_gap = 2;
    repeat (TAIL_TICKS) begin
      if ($urandom_range(0, 199) == 0) begin
        send_word(REQ_ADD, 6'($urandom), 6'($urandom), 5'($urandom), 1'($urandom));
      end else begin
        send_tick();
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (words_pending != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
